// ===== src/rrs_pkg.sv =====
// Types, status codes and the microcode program of the round-robin scheduler.
// Used by round_robin_scheduler_top and the testbench; depends on nothing else.
package rrs_pkg;

   localparam int MAX_PROCESSES = 16;
   localparam int IDX_W         = $clog2(MAX_PROCESSES);
   localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
   localparam int TIME_W        = 21;
   localparam int VAL_W         = 16;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // Opcodes of an input transaction.
   localparam logic OPC_LOAD  = 1'b0;
   localparam logic OPC_SCHED = 1'b1;

   // Status codes of a result transaction.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_ORDER     = 2'd2;
   localparam logic [1:0] ST_ALL_DONE  = 2'd3;

   typedef struct packed {
      logic             opcode;
      logic [VAL_W-1:0] arrival_time;
      logic [VAL_W-1:0] burst_time;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [3:0]        process_index;
      logic [TIME_W-1:0] slice_start;
      logic [VAL_W-1:0]  slice_length;
      logic              finished;
      logic [TIME_W-1:0] waiting_ticks;
      logic [TIME_W-1:0] turnaround_ticks;
   } rsp_type;

   // Datapath operations selected by a control word.
   localparam logic [2:0] DP_NONE     = 3'd0;
   localparam logic [2:0] DP_LOAD     = 3'd1;
   localparam logic [2:0] DP_INIT     = 3'd2;
   localparam logic [2:0] DP_SCAN     = 3'd3;
   localparam logic [2:0] DP_SLICE    = 3'd4;
   localparam logic [2:0] DP_COMPLETE = 3'd5;
   localparam logic [2:0] DP_EMIT     = 3'd6;

   // Jump conditions; when the condition holds the step counter loads the target.
   localparam logic [2:0] JC_NEVER  = 3'd0;
   localparam logic [2:0] JC_ALWAYS = 3'd1;
   localparam logic [2:0] JC_NO_REQ = 3'd2;
   localparam logic [2:0] JC_SCHED  = 3'd3;
   localparam logic [2:0] JC_EMPTY  = 3'd4;
   localparam logic [2:0] JC_MORE   = 3'd5;
   localparam logic [2:0] JC_NONE   = 3'd6;
   localparam logic [2:0] JC_BUSY   = 3'd7;

   localparam int PC_W = 3;

   // Program addresses.
   localparam logic [PC_W-1:0] PC_FETCH    = 3'd0;
   localparam logic [PC_W-1:0] PC_DISPATCH = 3'd1;
   localparam logic [PC_W-1:0] PC_LOAD     = 3'd2;
   localparam logic [PC_W-1:0] PC_INIT     = 3'd3;
   localparam logic [PC_W-1:0] PC_SCAN     = 3'd4;
   localparam logic [PC_W-1:0] PC_PICK     = 3'd5;
   localparam logic [PC_W-1:0] PC_COMPLETE = 3'd6;
   localparam logic [PC_W-1:0] PC_RESP     = 3'd7;

   typedef struct packed {
      logic [2:0]      dp_op;
      logic [2:0]      cond;
      logic [PC_W-1:0] target;
   } uword_type;

   // The control store. Without a taken jump the step counter advances by one.
   function automatic uword_type microcode(input logic [PC_W-1:0] pc);
      uword_type w;
      begin
         case (pc)
            PC_FETCH:    w = '{DP_NONE,     JC_NO_REQ, PC_FETCH};
            PC_DISPATCH: w = '{DP_NONE,     JC_SCHED,  PC_INIT};
            PC_LOAD:     w = '{DP_LOAD,     JC_ALWAYS, PC_RESP};
            PC_INIT:     w = '{DP_INIT,     JC_EMPTY,  PC_PICK};
            PC_SCAN:     w = '{DP_SCAN,     JC_MORE,   PC_SCAN};
            PC_PICK:     w = '{DP_SLICE,    JC_NONE,   PC_RESP};
            PC_COMPLETE: w = '{DP_COMPLETE, JC_NEVER,  PC_RESP};
            PC_RESP:     w = '{DP_EMIT,     JC_BUSY,   PC_RESP};
            default:     w = '{DP_NONE,     JC_ALWAYS, PC_FETCH};
         endcase
         return w;
      end
   endfunction

endpackage

// ===== src/round_robin_scheduler_top.sv =====
// Round-robin time-slice scheduler: a microcoded sequencer over a 16-entry process table.
// Depends on rrs_pkg for the transaction types, status codes and the control store.
//
// The block keeps a table of up to 16 processes. A load transaction appends one process
// (arrival times must not decrease) and passes through the fetch, dispatch, load and result
// steps. A schedule transaction serves one time slice: the scan step reads one table entry
// per cycle over the loaded processes, and that walk over the table sets how long it takes;
// the scan is skipped with an empty table, and the completion step when no process is left
// to serve. One transaction is worked on at a time; a new one is taken as soon as the
// sequencer is back at its fetch step, even while the previous result still waits in the
// output register. The time quantum is written through the register port at byte
// address 0 (reset value 10, a value of zero acts as one tick) and should only be changed
// while the block is idle. Reset is synchronous and takes effect on the next rising edge.
module round_robin_scheduler_top (
   input  logic                   clock,
   input  logic                   reset,
   // Input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rrs_pkg::req_type       req_data,
   // Result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rrs_pkg::rsp_type       rsp_data,
   // Register port
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [1:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import rrs_pkg::*;

   // Sequencer state.
   logic [PC_W-1:0]   pc_ff, pc_in;
   uword_type         uw;
   logic              jump;

   // Latched transaction and configuration.
   req_type           req_ff, req_in;
   logic [VAL_W-1:0]  quantum_ff, quantum_in;

   // Scheduler state.
   logic [CNT_W-1:0]  loaded_ff, loaded_in;
   logic [IDX_W-1:0]  scan_pos_ff, scan_pos_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [VAL_W-1:0]  last_arr_ff, last_arr_in;

   // Scan bookkeeping: whether the arrived prefix still runs, and the first unfinished
   // process at or after the scan position, anywhere in the arrived prefix, and beyond it.
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              run_ff, run_in;
   logic              fnd_a_ff, fnd_a_in, fnd_b_ff, fnd_b_in, fnd_c_ff, fnd_c_in;
   logic [IDX_W-1:0]  sel_a_ff, sel_a_in, sel_b_ff, sel_b_in, sel_c_ff, sel_c_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;

   // Result under construction and the output register.
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Process table.
   logic [VAL_W-1:0]  arrival_mem   [MAX_PROCESSES];
   logic [VAL_W-1:0]  burst_mem     [MAX_PROCESSES];
   logic [VAL_W-1:0]  remaining_mem [MAX_PROCESSES];

   logic              wr_load, wr_rem;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [VAL_W-1:0]  rem_wdata;
   logic [VAL_W-1:0]  rd_arrival, rd_burst, rd_remaining;

   // Combinational helpers.
   logic              req_accept, rsp_busy, cfg_write;
   logic              none_found, idle_jump, more;
   logic [IDX_W-1:0]  pick_idx;
   logic              entry_arrived, entry_open;
   logic [VAL_W-1:0]  q_eff, len;
   logic [TIME_W-1:0] start;
   logic [TIME_W:0]   t_sum;
   logic [TIME_W-1:0] turn;

   assign uw         = microcode(pc_ff);
   assign req_stall  = (pc_ff != PC_FETCH);
   assign req_accept = req_valid && !req_stall;
   assign rsp_busy   = rsp_valid_ff && rsp_stall;
   assign cfg_write  = psel && penable && pwrite && pready;

   assign pready    = 1'b1;
   assign prdata    = {16'd0, quantum_ff};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Candidate selection after the scan: resume from the scan position, otherwise wrap
   // to the head of the arrived prefix, otherwise jump ahead to the next arrival.
   assign none_found = !fnd_a_ff && !fnd_b_ff && !fnd_c_ff;
   assign idle_jump  = !fnd_a_ff && !fnd_b_ff;
   assign pick_idx   = fnd_a_ff ? sel_a_ff : (fnd_b_ff ? sel_b_ff : sel_c_ff);
   assign more       = ({1'b0, idx_ff} + CNT_W'(1)) < loaded_ff;

   always_comb begin
      case (uw.dp_op)
         DP_SCAN:  rd_addr = idx_ff;
         DP_SLICE: rd_addr = pick_idx;
         default:  rd_addr = pick_ff;
      endcase
   end

   assign rd_arrival   = arrival_mem[rd_addr];
   assign rd_burst     = burst_mem[rd_addr];
   assign rd_remaining = remaining_mem[rd_addr];

   assign entry_arrived = run_ff && ({5'd0, rd_arrival} <= time_ff);
   assign entry_open    = (rd_remaining != '0);

   assign q_eff = (quantum_ff == '0) ? VAL_W'(1) : quantum_ff;
   assign len   = (rd_remaining < q_eff) ? rd_remaining : q_eff;
   assign start = idle_jump ? {5'd0, rd_arrival} : time_ff;
   assign t_sum = {1'b0, start} + {6'd0, len};
   assign turn  = time_ff - {5'd0, rd_arrival};

   // Jump conditions.
   always_comb begin
      case (uw.cond)
         JC_NEVER:  jump = 1'b0;
         JC_ALWAYS: jump = 1'b1;
         JC_NO_REQ: jump = !req_valid;
         JC_SCHED:  jump = (req_ff.opcode == OPC_SCHED);
         JC_EMPTY:  jump = (loaded_ff == '0);
         JC_MORE:   jump = more;
         JC_NONE:   jump = none_found;
         JC_BUSY:   jump = rsp_busy;
         default:   jump = 1'b0;
      endcase
      pc_in = jump ? uw.target : pc_ff + PC_W'(1);
   end

   // Datapath.
   always_comb begin
      req_in       = req_accept ? req_data : req_ff;
      quantum_in   = cfg_write ? pwdata[VAL_W-1:0] : quantum_ff;
      loaded_in    = loaded_ff;
      scan_pos_in  = scan_pos_ff;
      time_in      = time_ff;
      last_arr_in  = last_arr_ff;
      idx_in       = idx_ff;
      run_in       = run_ff;
      fnd_a_in     = fnd_a_ff;
      fnd_b_in     = fnd_b_ff;
      fnd_c_in     = fnd_c_ff;
      sel_a_in     = sel_a_ff;
      sel_b_in     = sel_b_ff;
      sel_c_in     = sel_c_ff;
      pick_in      = pick_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_load      = 1'b0;
      wr_rem       = 1'b0;
      wr_addr      = loaded_ff[IDX_W-1:0];
      rem_wdata    = req_ff.burst_time;

      case (uw.dp_op)
         DP_LOAD: begin
            res_in = '0;
            if (loaded_ff >= CNT_W'(MAX_PROCESSES)) begin
               res_in.status = ST_FULL;
            end else if (req_ff.arrival_time < last_arr_ff) begin
               res_in.status = ST_ORDER;
            end else begin
               wr_load              = 1'b1;
               wr_rem               = 1'b1;
               last_arr_in          = req_ff.arrival_time;
               loaded_in            = loaded_ff + CNT_W'(1);
               res_in.status        = ST_OK;
               res_in.process_index = 4'(loaded_ff[IDX_W-1:0]);
            end
         end
         DP_INIT: begin
            idx_in   = '0;
            run_in   = 1'b1;
            fnd_a_in = 1'b0;
            fnd_b_in = 1'b0;
            fnd_c_in = 1'b0;
         end
         DP_SCAN: begin
            run_in = entry_arrived;
            idx_in = idx_ff + IDX_W'(1);
            if (entry_arrived && entry_open && !fnd_a_ff && (idx_ff >= scan_pos_ff)) begin
               fnd_a_in = 1'b1;
               sel_a_in = idx_ff;
            end
            if (entry_arrived && entry_open && !fnd_b_ff) begin
               fnd_b_in = 1'b1;
               sel_b_in = idx_ff;
            end
            if (!entry_arrived && entry_open && !fnd_c_ff) begin
               fnd_c_in = 1'b1;
               sel_c_in = idx_ff;
            end
         end
         DP_SLICE: begin
            res_in = '0;
            if (none_found) begin
               res_in.status = ST_ALL_DONE;
            end else begin
               wr_rem               = 1'b1;
               wr_addr              = pick_idx;
               rem_wdata            = rd_remaining - len;
               pick_in              = pick_idx;
               time_in              = t_sum[TIME_W] ? TIME_MAX : t_sum[TIME_W-1:0];
               scan_pos_in          = (pick_idx == IDX_W'(MAX_PROCESSES - 1)) ?
                                      '0 : pick_idx + IDX_W'(1);
               res_in.status        = ST_OK;
               res_in.process_index = 4'(pick_idx);
               res_in.slice_start   = start;
               res_in.slice_length  = len;
               res_in.finished      = (rd_remaining == len);
            end
         end
         DP_COMPLETE: begin
            if (res_ff.finished) begin
               res_in.turnaround_ticks = turn;
               res_in.waiting_ticks    = (turn >= {5'd0, rd_burst}) ?
                                         turn - {5'd0, rd_burst} : '0;
            end
         end
         DP_EMIT: begin
            if (!rsp_busy) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_FETCH;
         quantum_ff   <= VAL_W'(10);
         loaded_ff    <= '0;
         scan_pos_ff  <= '0;
         time_ff      <= '0;
         last_arr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         quantum_ff   <= quantum_in;
         loaded_ff    <= loaded_in;
         scan_pos_ff  <= scan_pos_in;
         time_ff      <= time_in;
         last_arr_ff  <= last_arr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      run_ff      <= run_in;
      fnd_a_ff    <= fnd_a_in;
      fnd_b_ff    <= fnd_b_in;
      fnd_c_ff    <= fnd_c_in;
      sel_a_ff    <= sel_a_in;
      sel_b_ff    <= sel_b_in;
      sel_c_ff    <= sel_c_in;
      pick_ff     <= pick_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Process table writes: a load fills all three fields, a slice updates the remaining time.
   always_ff @(posedge clock) begin
      if (wr_load) begin
         arrival_mem[wr_addr] <= req_ff.arrival_time;
         burst_mem[wr_addr]   <= req_ff.burst_time;
      end
      if (wr_rem) begin
         remaining_mem[wr_addr] <= rem_wdata;
      end
   end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the round-robin time-slice scheduler.
// Needs rrs_pkg and round_robin_scheduler_top; every check is computed here.
module testbench;
   import rrs_pkg::*;

   // The quantum register is the only one; the block does not decode the address, and byte address 0 is used.
   localparam logic [1:0] QUANTUM_ADDR  = 2'd0;
   localparam int         IDLE_PERCENT  = 19;
   localparam int         HOLD_CYCLES   = 150;
   // Margin for a schedule transaction that scans the full table to pass through the block.
   localparam int         SETTLE_CYCLES = MAX_PROCESSES + 8;
   localparam int         PRINT_LIMIT   = 100;
   localparam int         RUN_LIMIT     = 4_000_000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [1:0]  paddr     = '0;
   logic [31:0] pwdata    = '0;
   logic [31:0] prdata;
   logic        pready;

   // When set, neither side of the block pauses: this gives a stretch at full rate.
   bit          quiet_mode   = 1'b0;
   // Raised by a test to make the result side start a counted hold-off.
   bit          hold_request = 1'b0;
   int          mismatch_count = 0;

   // Results still owed by the block, oldest first.
   rsp_type     awaited_outcomes[$];

   // Our own copy of the scheduler's process table, clock and register.
   logic [15:0] proc_arrival   [MAX_PROCESSES];
   logic [15:0] proc_burst     [MAX_PROCESSES];
   logic [15:0] proc_remaining [MAX_PROCESSES];
   int          procs_loaded    = 0;
   int          next_scan       = 0;
   logic [20:0] now_tick        = '0;
   logic [15:0] latest_arrival  = '0;
   logic [15:0] quantum_setting = 16'd10;

   round_robin_scheduler_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // A single runaway guard: the slowest correct run finishes well inside this time.
   initial begin
      #(RUN_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("ERROR at %0t: %s", $time, what);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] seen, input logic [31:0] want);
      if (seen !== want) begin
         report_mismatch($sformatf("%s is %0d, should be %0d", name, seen, want));
      end
   endtask

   // Lowest index in [from, to) whose process still has work left, or -1.
   function automatic int first_unfinished(input int from, input int to);
      for (int i = from; i < to && i < MAX_PROCESSES; i++) begin
         if (proc_remaining[i] != 0) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Works out the result of one input transaction and advances our copy of the state.
   function automatic rsp_type scheduler_outcome(input req_type item);
      rsp_type     r;
      int          arrived;
      int          pick;
      logic [15:0] q;
      logic [15:0] len;
      logic [21:0] sum;
      logic [20:0] turn;
      r = '0;
      if (item.opcode == OPC_LOAD) begin
         if (procs_loaded >= MAX_PROCESSES) begin
            r.status = ST_FULL;
         end else if (item.arrival_time < latest_arrival) begin
            r.status = ST_ORDER;
         end else begin
            proc_arrival[procs_loaded]   = item.arrival_time;
            proc_burst[procs_loaded]     = item.burst_time;
            proc_remaining[procs_loaded] = item.burst_time;
            latest_arrival               = item.arrival_time;
            r.process_index              = 4'(procs_loaded);
            procs_loaded++;
         end
         return r;
      end

      // Arrivals never decrease, so the processes that have arrived form a prefix.
      arrived = 0;
      while (arrived < procs_loaded && 21'(proc_arrival[arrived]) <= now_tick) begin
         arrived++;
      end
      pick = first_unfinished(next_scan, arrived);
      if (pick < 0) begin
         pick = first_unfinished(0, arrived);
      end
      if (pick < 0) begin
         // Nothing ready: jump ahead to the first process still to come, if any.
         pick = first_unfinished(arrived, procs_loaded);
         if (pick < 0) begin
            r.status = ST_ALL_DONE;
            return r;
         end
         now_tick = 21'(proc_arrival[pick]);
      end

      q   = (quantum_setting == 0) ? 16'd1 : quantum_setting;
      len = (proc_remaining[pick] < q) ? proc_remaining[pick] : q;
      r.process_index = 4'(pick);
      r.slice_start   = now_tick;
      r.slice_length  = len;
      proc_remaining[pick] -= len;
      sum       = {1'b0, now_tick} + 22'(len);
      now_tick  = (sum > 22'(TIME_MAX)) ? TIME_MAX : sum[20:0];
      next_scan = (pick + 1 < MAX_PROCESSES) ? pick + 1 : 0;
      if (proc_remaining[pick] == 0) begin
         turn               = now_tick - 21'(proc_arrival[pick]);
         r.finished         = 1'b1;
         r.waiting_ticks    = (turn >= 21'(proc_burst[pick])) ? turn - 21'(proc_burst[pick]) : '0;
         r.turnaround_ticks = turn;
      end
      return r;
   endfunction

   // Offers one transaction, entered and left at a falling edge. Valid is left high so
   // that back-to-back transactions need no second assignment in the same step.
   task automatic send_request(input logic op, input logic [15:0] arrival,
                               input logic [15:0] burst, output rsp_type outcome);
      req_type item;
      item = '{opcode: op, arrival_time: arrival, burst_time: burst};
      while (!quiet_mode && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      outcome = scheduler_outcome(item);
      awaited_outcomes.push_back(outcome);
      @(negedge clock);
   endtask

   // Stops offering and waits until the block has answered everything.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (awaited_outcomes.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register transfer: a setup phase, then an access phase that ends when pready is high,
   // then an idle phase so that a following transfer starts at a later falling edge.
   task automatic apb_access(input logic write, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= QUANTUM_ADDR;
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_quantum_register();
      logic [31:0] seen;
      apb_access(1'b0, '0, seen);
      check_field("time_quantum register", {16'd0, seen[15:0]}, {16'd0, quantum_setting});
   endtask

   task automatic program_quantum(input logic [15:0] value);
      logic [31:0] unused;
      apb_access(1'b1, {16'd0, value}, unused);
      quantum_setting = value;
      check_quantum_register();
   endtask

   task automatic test_register_reset_value();
      check_quantum_register();
   endtask

   // Hand-picked transactions: empty table, zero burst, arrivals out of order, idle jumps,
   // scan wrap-around and the zero quantum.
   task automatic test_directed_cases();
      rsp_type outcome;
      send_request(OPC_SCHED, 16'd0,     16'd0,     outcome);
      send_request(OPC_LOAD,  16'd5,     16'd0,     outcome);
      send_request(OPC_SCHED, 16'hffff,  16'hffff,  outcome);
      send_request(OPC_LOAD,  16'd0,     16'd7,     outcome);
      send_request(OPC_LOAD,  16'd4,     16'hffff,  outcome);
      send_request(OPC_LOAD,  16'd5,     16'd1,     outcome);
      send_request(OPC_LOAD,  16'd40,    16'd25,    outcome);
      repeat (5) send_request(OPC_SCHED, 16'd0, 16'd0, outcome);
      wait_until_idle();
      program_quantum(16'd0);
      send_request(OPC_LOAD,  16'd80,    16'd3,     outcome);
      send_request(OPC_LOAD,  16'd80,    16'd2,     outcome);
      repeat (6) send_request(OPC_SCHED, 16'd0, 16'd0, outcome);
   endtask

   // Mostly schedule transactions with a few loads; some loads arrive out of order on purpose.
   // One table slot is kept free for the closing test.
   task automatic test_random_traffic(input int count, input logic [15:0] slice_quantum,
                                      input bit calm);
      rsp_type     outcome;
      logic        op;
      logic [15:0] arrival;
      logic [15:0] burst;
      int          roll;
      int          base;
      int          nearby;
      int          pick_burst;
      wait_until_idle();
      program_quantum(slice_quantum);
      quiet_mode = calm;
      repeat (count) begin
         roll    = $urandom_range(0, 99);
         op      = OPC_SCHED;
         arrival = 16'($urandom);
         burst   = 16'($urandom);
         if (roll < 7 && procs_loaded < MAX_PROCESSES - 1) begin
            op   = OPC_LOAD;
            base = latest_arrival;
            // Now and then place the arrival near the scheduler's clock so it may jump ahead.
            if ($urandom_range(0, 2) == 0) begin
               nearby = (now_tick > 21'd50000) ? 50000 : int'(now_tick);
               if (nearby > base) begin
                  base = nearby;
               end
            end
            base += $urandom_range(0, 300);
            arrival = 16'((base > 60000) ? ((latest_arrival > 60000) ? latest_arrival : 60000)
                                         : base);
            pick_burst = $urandom_range(0, 19);
            if (pick_burst == 0) begin
               burst = 16'd0;
            end else if (pick_burst < 3) begin
               burst = 16'($urandom_range(0, 65535));
            end else begin
               burst = 16'($urandom_range(1, 600));
            end
         end else if (roll < 10 && latest_arrival != 0) begin
            op      = OPC_LOAD;
            arrival = 16'($urandom_range(0, latest_arrival - 1));
         end
         send_request(op, arrival, burst, outcome);
      end
      quiet_mode = 1'b0;
   endtask

   // The result side holds off for a long while as transactions keep coming, so the block
   // fills up and has to stall its input.
   task automatic test_output_backpressure();
      rsp_type outcome;
      wait_until_idle();
      hold_request = 1'b1;
      repeat (16) send_request(OPC_SCHED, 16'($urandom), 16'($urandom), outcome);
   endtask

   // Largest quantum, latest arrival and longest burst; then the full table, and slices
   // until every process is done.
   task automatic test_table_full_and_wide_quantum();
      rsp_type outcome;
      wait_until_idle();
      program_quantum(16'hffff);
      while (procs_loaded < MAX_PROCESSES) begin
         send_request(OPC_LOAD, 16'hffff, 16'hffff, outcome);
      end
      send_request(OPC_LOAD, 16'hffff, 16'd1, outcome);
      send_request(OPC_LOAD, 16'd0,    16'd1, outcome);
      do begin
         send_request(OPC_SCHED, 16'd0, 16'd0, outcome);
      end while (outcome.status != ST_ALL_DONE);
      send_request(OPC_SCHED, 16'hffff, 16'hffff, outcome);
   endtask

   // Result side: random stalls, or a counted hold-off when a test asks for one.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet_mode && ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   // Every accepted result transaction is compared field by field with the oldest
   // expectation; a result with nothing outstanding is itself a failure.
   initial begin
      rsp_type due;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("result transaction with nothing outstanding");
            end else begin
               due = awaited_outcomes.pop_front();
               check_field("status",           32'(rsp_data.status),
                           32'(due.status));
               check_field("process_index",    32'(rsp_data.process_index),
                           32'(due.process_index));
               check_field("slice_start",      32'(rsp_data.slice_start),
                           32'(due.slice_start));
               check_field("slice_length",     32'(rsp_data.slice_length),
                           32'(due.slice_length));
               check_field("finished",         32'(rsp_data.finished),
                           32'(due.finished));
               check_field("waiting_ticks",    32'(rsp_data.waiting_ticks),
                           32'(due.waiting_ticks));
               check_field("turnaround_ticks", 32'(rsp_data.turnaround_ticks),
                           32'(due.turnaround_ticks));
            end
         end
      end
   end

   // Test sequence. Reset is held from the start and released at a falling edge; after
   // that the tests run in turn, each starting and ending at a falling edge.
   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_register_reset_value();
      test_directed_cases();
      test_random_traffic(150, 16'($urandom_range(2, 16)), 1'b0);
      // A long stretch at full rate on both sides with the smallest real quantum.
      test_random_traffic(120, 16'd1, 1'b1);
      test_random_traffic(150, 16'($urandom_range(17, 300)), 1'b0);
      test_output_backpressure();
      test_table_full_and_wide_quantum();
      wait_until_idle();
      if (awaited_outcomes.size() != 0) begin
         report_mismatch("result transactions still outstanding at the end");
      end
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
